// ===== hw/rtl/prime_list_trial_division_core_macros.svh =====
// Assertion macros used by the checker file of the prime list core.
`ifndef PRIME_LIST_TRIAL_DIVISION_CORE_MACROS_SVH
`define PRIME_LIST_TRIAL_DIVISION_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLTD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pltd assertion failed");

// Next-cycle implication, disabled during reset.
`define PLTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pltd assertion failed");

`endif

// ===== hw/rtl/pltd_pkg.sv =====
// Package with widths, constants and shared types of the prime list core.
package pltd_pkg;

   localparam int LimitW          = 8;
   localparam int CandW           = LimitW + 1;
   localparam int MaxLimitDefault = 255;
   localparam int FirstPrime      = 2;

   typedef struct packed {
      logic              start;
      logic [LimitW-1:0] dividend;
      logic [LimitW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

// ===== hw/rtl/pltd_req_if.sv =====
// Handshake interface of the limit request channel.
interface pltd_req_if import pltd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LimitW-1:0] limit;

   modport source (output valid, output limit, input ready);
   modport sink (input valid, input limit, output ready);
endinterface

// ===== hw/rtl/pltd_rsp_if.sv =====
// Handshake interface of the prime response channel.
interface pltd_rsp_if import pltd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LimitW-1:0] prime;
   logic              last;

   modport source (output valid, output prime, output last, input ready);
   modport sink (input valid, input prime, input last, output ready);
endinterface

// ===== hw/rtl/pltd_divider.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
module pltd_divider import pltd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  div_req_type    div_req,
   output div_status_type div_status
);

   localparam int CntW = $clog2(LimitW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [LimitW-1:0] dvd_ff, dvd_in;
   logic [LimitW-1:0] dsr_ff, dsr_in;
   logic [LimitW-1:0] rem_ff, rem_in;
   logic [LimitW:0]   trial;
   logic [LimitW:0]   diff;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[LimitW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         rem_in = fits ? diff[LimitW-1:0] : trial[LimitW-1:0];
         dvd_in = {dvd_ff[LimitW-2:0], 1'b0};
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(LimitW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_status.done     = done_ff;
   assign div_status.rem_zero = (rem_ff == '0);

endmodule

// ===== hw/rtl/pltd_seq.sv =====
// Sequencer: walks candidates and divisors, holds one prime back for the last flag.
module pltd_seq import pltd_pkg::*; #(
   parameter int MAX_LIMIT = MaxLimitDefault
) (
   input  logic           clock,
   input  logic           reset,
   pltd_req_if.sink       req,
   pltd_rsp_if.source     rsp,
   output div_req_type    div_req,
   input  div_status_type div_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_TEST,
      ST_WAIT,
      ST_FOUND,
      ST_FLUSH
   } state_type;

   state_type         state_ff, state_in;
   logic [LimitW-1:0] lim_ff, lim_in;
   logic [CandW-1:0]  n_ff, n_in;
   logic [LimitW-1:0] d_ff, d_in;
   logic [LimitW-1:0] pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LimitW-1:0] rsp_prime_ff, rsp_prime_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.prime = rsp_prime_ff;
   assign rsp.last  = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      lim_in        = lim_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_prime_in  = rsp_prime_ff;
      rsp_last_in   = rsp_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = n_ff[LimitW-1:0];
      div_req.divisor  = d_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               lim_in        = (32'(req.limit) > MAX_LIMIT) ? LimitW'(MAX_LIMIT) : req.limit;
               n_in          = CandW'(FirstPrime);
               pend_valid_in = 1'b0;
               state_in      = ST_CAND;
            end
         end
         ST_CAND: begin
            if (n_ff > {1'b0, lim_ff}) begin
               state_in = ST_FLUSH;
            end else begin
               d_in     = LimitW'(FirstPrime);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (d_ff == n_ff[LimitW-1:0]) begin
               state_in = ST_FOUND;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  n_in     = n_ff + CandW'(1);
                  state_in = ST_CAND;
               end else begin
                  d_in     = d_ff + LimitW'(1);
                  state_in = ST_TEST;
               end
            end
         end
         ST_FOUND: begin
            if (!pend_valid_ff) begin
               pend_in       = n_ff[LimitW-1:0];
               pend_valid_in = 1'b1;
               n_in          = n_ff + CandW'(1);
               state_in      = ST_CAND;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = pend_ff;
               rsp_last_in  = 1'b0;
               pend_in      = n_ff[LimitW-1:0];
               n_in         = n_ff + CandW'(1);
               state_in     = ST_CAND;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_prime_in  = pend_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lim_ff       <= lim_in;
      n_ff         <= n_in;
      d_ff         <= d_in;
      pend_ff      <= pend_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ===== hw/rtl/prime_list_trial_division_core.sv =====
// Prime list core: emits every prime up to a given limit, ascending, last one flagged.
//
// req_chan takes one 8-bit limit; the limit saturates to MAX_LIMIT. rsp_chan
// returns one transfer per prime p with 2 <= p <= limit, ascending, and last
// high on the final one. A limit below two gives no transfers at all.
// Each candidate n is tested against divisors 2..n-1 in turn, up to the first
// that divides it, on one shared remainder unit that resolves one quotient bit
// per cycle. A prime n runs through all n-2 divisors, a composite through
// p-1 divisors for its smallest factor p.
// req_chan.ready is high only while the core is idle: one limit at a time.
// Each prime is held back until the next one is found (or the run ends) so
// that the last flag is known; a one-deep output register carries it.
// When the receiver stalls, the output register holds and the search halts
// at the next prime found. Reset is synchronous and returns the core to idle
// with nothing pending; no memory needs clearing.
module prime_list_trial_division_core import pltd_pkg::*; #(
   parameter int MAX_LIMIT = MaxLimitDefault
) (
   input  logic       clock,
   input  logic       reset,
   pltd_req_if.sink   req_chan,
   pltd_rsp_if.source rsp_chan
);

   div_req_type    div_req;
   div_status_type div_status;

   pltd_seq #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .div_req    (div_req),
      .div_status (div_status)
   );

   pltd_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .div_req    (div_req),
      .div_status (div_status)
   );

endmodule

// ===== hw/rtl/pltd_checker.sv =====
// Port checker of the prime list core, bound to the top level.
`include "prime_list_trial_division_core_macros.svh"

module pltd_checker import pltd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [LimitW-1:0] rsp_prime,
   input logic              rsp_last
);

   logic rsp_mid_xfer;
   logic rsp_stall;
   logic prime_shape_ok;

   assign rsp_mid_xfer   = rsp_valid && rsp_ready && !rsp_last;
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign prime_shape_ok = (rsp_prime == LimitW'(FirstPrime))
                           || (rsp_prime[0] && rsp_prime > LimitW'(FirstPrime));

   `PLTD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `PLTD_ASSERT_NEXT(a_run_open_after_mid, clock, reset, rsp_mid_xfer, !req_ready || rsp_valid)
   `PLTD_ASSERT_NOW(a_prime_shape, clock, reset, rsp_valid, prime_shape_ok)
   `PLTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_prime) && $stable(rsp_last))

endmodule

bind prime_list_trial_division_core pltd_checker u_pltd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_prime (rsp_chan.prime),
   .rsp_last  (rsp_chan.last)
);

// ===== sim/prime_list_trial_division_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the prime list core: corner and random limits in, every prime checked against a local trial division.
module prime_list_trial_division_core_tb;
   import pltd_pkg::*;

   localparam int MAX_LIMIT    = MaxLimitDefault;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_ITEMS = 100;
   localparam int QUIET_TAIL   = 15;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [LimitW-1:0] prime;
      logic              last;
   } prime_rsp_type;

   logic clock;
   logic reset;

   pltd_req_if req_if ();
   pltd_rsp_if rsp_if ();

   prime_list_trial_division_core #(.MAX_LIMIT(MAX_LIMIT)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [LimitW-1:0] limit_backlog[$];
   prime_rsp_type     primes_due[$];

   int   corner_limits[16] = '{0, 1, 2, 3, 4, 5, 8, 11, 12, 127, 128, 250, 251, 255, 2, 0};
   int   mismatches   = 0;
   int   limits_taken = 0;
   int   quiet_from   = 0;
   int   idle_cycles  = 0;
   int   req_gap      = 0;
   int   req_calm     = 0;
   int   rsp_gap      = 0;
   int   rsp_calm     = 0;
   logic req_taken    = 1'b0;
   prime_rsp_type due;

   function automatic void enumerate_primes(input logic [LimitW-1:0] limit);
      int       top;
      bit       composite;
      int       found[$];
      prime_rsp_type entry;
      top = (int'(limit) > MAX_LIMIT) ? MAX_LIMIT : int'(limit);
      for (int n = FirstPrime; n <= top; n++) begin
         composite = 1'b0;
         for (int d = FirstPrime; d < n && !composite; d++) begin
            if (n % d == 0) composite = 1'b1;
         end
         if (!composite) found.push_back(n);
      end
      foreach (found[i]) begin
         entry.prime = found[i][LimitW-1:0];
         entry.last  = (i == found.size() - 1);
         primes_due.push_back(entry);
      end
   endfunction

   task automatic report_miss(input string what, input int exp_val, input int act_val);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
   endtask

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // limit driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_taken) void'(limit_backlog.pop_front());
         if (req_calm > 0) req_calm--;
         else if ($urandom_range(0, 63) == 0) req_calm = $urandom_range(20, 200);
         if (req_if.valid && !req_taken) begin
            // hold until transfer
         end else if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (limit_backlog.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (limits_taken < quiet_from && req_calm == 0
                      && $urandom_range(0, 2) == 0) begin
            req_gap = $urandom_range(0, 3);
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid <= 1'b1;
            req_if.limit <= limit_backlog[0];
         end
      end
   end

   // response ready driver
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b1;
         rsp_gap = 0;
      end else begin
         if (rsp_calm > 0) rsp_calm--;
         else if ($urandom_range(0, 63) == 0) rsp_calm = $urandom_range(20, 200);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else if (limits_taken < quiet_from && rsp_calm == 0
                      && $urandom_range(0, rsp_if.valid ? 2 : 7) == 0) begin
            rsp_gap = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            enumerate_primes(req_if.limit);
            limits_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (primes_due.size() == 0) begin
               report_miss("unexpected prime", -1, rsp_if.prime);
            end else begin
               due = primes_due.pop_front();
               if (due.prime !== rsp_if.prime) report_miss("prime", due.prime, rsp_if.prime);
               if (due.last !== rsp_if.last) report_miss("last", due.last, rsp_if.last);
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.limit = '0;
      rsp_if.ready = 1'b1;

      // range edges, below two, prime and composite limits, full range
      foreach (corner_limits[i])
         limit_backlog.push_back(LimitW'(corner_limits[i]));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 88)
            limit_backlog.push_back(LimitW'($urandom_range(0, 63)));
         else if (pick < 97)
            limit_backlog.push_back(LimitW'($urandom_range(64, 191)));
         else
            limit_backlog.push_back(LimitW'($urandom_range(192, 255)));
      end
      quiet_from = limit_backlog.size() - QUIET_TAIL;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (limit_backlog.size() != 0 || req_if.valid) @(posedge clock);
      while (primes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
